/* hdl/cse_pkg.sv */
package cse_pkg;

    // vector length limit and counter width
    localparam int MAX_LEN     = 4096;
    localparam int CNT_W       = $clog2(MAX_LEN + 1);

    // datapath widths
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 2 * ELEM_W;
    localparam int SUM_W       = 48;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int REM_W       = ROOT_W + 3;
    localparam int NORM_W      = 22;
    localparam int SIM_W       = 16;
    localparam int FRAC_SHIFT  = 15;
    localparam int DEN_W       = 2 * NORM_W;
    localparam int DVD_W       = SUM_W + FRAC_SHIFT;
    localparam int QT_W        = SIM_W + 1;

    // iteration counts
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int SQ_CNT_W    = $clog2(SQRT_STEPS);
    localparam int DIV_STEPS   = DVD_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // queue between front and back
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

    // saturation limits
    localparam logic [NORM_W-1:0]       NORM_MAX = '1;
    localparam logic signed [SUM_W-1:0] SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic signed [SIM_W-1:0] SIM_MAX  = {1'b0, {(SIM_W-1){1'b1}}};
    localparam logic signed [SIM_W-1:0] SIM_MIN  = {1'b1, {(SIM_W-1){1'b0}}};

    // finished sums of one vector pair
    typedef struct packed {
        logic signed [SUM_W-1:0] sum_ab;
        logic signed [SUM_W-1:0] sum_aa;
        logic signed [SUM_W-1:0] sum_bb;
        logic                    ovf;
    } acc_snap_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQRT,
        BK_MUL,
        BK_PREP,
        BK_DIV,
        BK_OUT
    } back_state_t;

    // saturating add of a product into a running sum
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  s,
        input logic signed [PROD_W-1:0] p
    );
        logic signed [SUM_W:0] r;
        r = {s[SUM_W-1], s} + {{(SUM_W+1-PROD_W){p[PROD_W-1]}}, p};
        if (r[SUM_W] != r[SUM_W-1]) begin
            sat_add = r[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sat_add = r[SUM_W-1:0];
        end
    endfunction

endpackage

/* hdl/cse_front.sv */
module cse_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [cse_pkg::ELEM_W-1:0] s_elem_a,
    input  logic signed [cse_pkg::ELEM_W-1:0] s_elem_b,
    input  logic                            s_last_elem,
    output logic                            push,
    output cse_pkg::acc_snap_t              push_data,
    input  logic                            fifo_full
);
    import cse_pkg::*;

    logic             s_acc;
    logic             take;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;

    logic                     p_valid_reg, p_valid_next;
    logic signed [PROD_W-1:0] p_ab_reg, p_aa_reg, p_bb_reg;
    logic                     p_take_reg, p_last_reg, p_ovf_reg;

    logic signed [SUM_W-1:0] sum_ab_reg, sum_aa_reg, sum_bb_reg;
    logic signed [SUM_W-1:0] sum_ab_next, sum_aa_next, sum_bb_next;
    logic signed [SUM_W-1:0] add_ab, add_aa, add_bb;
    logic                    p_consume;

    // product stage holds while a last request waits on a full queue
    assign s_ready   = !(p_valid_reg && p_last_reg && fifo_full);
    assign s_acc     = s_valid && s_ready;
    assign take      = (cnt_reg < CNT_W'(MAX_LEN));
    assign p_consume = p_valid_reg && s_ready;

    // element count and overflow tracking
    always_comb begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (s_acc) begin
            if (s_last_elem) begin
                cnt_next = '0;
                ovf_next = 1'b0;
            end else if (take) begin
                cnt_next = cnt_reg + 1'b1;
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    assign p_valid_next = s_ready ? s_valid : p_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            ovf_reg     <= 1'b0;
            p_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            ovf_reg     <= ovf_next;
            p_valid_reg <= p_valid_next;
        end
    end

    // product registers
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p_ab_reg   <= s_elem_a * s_elem_b;
            p_aa_reg   <= s_elem_a * s_elem_a;
            p_bb_reg   <= s_elem_b * s_elem_b;
            p_take_reg <= take;
            p_last_reg <= s_last_elem;
            p_ovf_reg  <= ovf_reg || !take;
        end
    end

    // saturating accumulation
    always_comb begin
        add_ab = p_take_reg ? sat_add(sum_ab_reg, p_ab_reg) : sum_ab_reg;
        add_aa = p_take_reg ? sat_add(sum_aa_reg, p_aa_reg) : sum_aa_reg;
        add_bb = p_take_reg ? sat_add(sum_bb_reg, p_bb_reg) : sum_bb_reg;
        sum_ab_next = sum_ab_reg;
        sum_aa_next = sum_aa_reg;
        sum_bb_next = sum_bb_reg;
        if (p_consume) begin
            if (p_last_reg) begin
                sum_ab_next = '0;
                sum_aa_next = '0;
                sum_bb_next = '0;
            end else begin
                sum_ab_next = add_ab;
                sum_aa_next = add_aa;
                sum_bb_next = add_bb;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_ab_reg <= '0;
            sum_aa_reg <= '0;
            sum_bb_reg <= '0;
        end else begin
            sum_ab_reg <= sum_ab_next;
            sum_aa_reg <= sum_aa_next;
            sum_bb_reg <= sum_bb_next;
        end
    end

    // hand finished sums to the queue
    assign push             = p_valid_reg && p_last_reg && !fifo_full;
    assign push_data.sum_ab = add_ab;
    assign push_data.sum_aa = add_aa;
    assign push_data.sum_bb = add_bb;
    assign push_data.ovf    = p_ovf_reg;

endmodule

/* hdl/cse_fifo.sv */
module cse_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  cse_pkg::acc_snap_t wr_data,
    output logic               full,
    input  logic               rd_en,
    output cse_pkg::acc_snap_t rd_data,
    output logic               empty
);
    import cse_pkg::*;

    acc_snap_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]  count_reg, count_next;

    assign full    = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (wr_en) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn) wr_en |-> !full)
        else $error("queue written while full");
    assert property (@(posedge aclk) disable iff (!aresetn) rd_en |-> !empty)
        else $error("queue read while empty");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

/* hdl/cse_isqrt.sv */
module cse_isqrt (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [cse_pkg::SUM_W-1:0]    value,
    output logic                         done,
    output logic [cse_pkg::ROOT_W-1:0]   root
);
    import cse_pkg::*;

    logic                busy_reg, done_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0]    x_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [REM_W-1:0]    rem_sh, trial;
    logic                ge;

    // one result bit per step, two radicand bits brought down
    assign rem_sh = {rem_reg[REM_W-3:0], x_reg[SUM_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == SQ_CNT_W'(SQRT_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // radicand, remainder and root
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= {x_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* hdl/cse_back.sv */
module cse_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              fifo_empty,
    output logic                              pop,
    input  cse_pkg::acc_snap_t                rd_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [cse_pkg::SIM_W-1:0]  m_similarity,
    output logic signed [cse_pkg::SUM_W-1:0]  m_dot_product,
    output logic [cse_pkg::NORM_W-1:0]        m_norm_a,
    output logic [cse_pkg::NORM_W-1:0]        m_norm_b,
    output logic                              m_zero_norm,
    output logic                              m_overflow
);
    import cse_pkg::*;

    back_state_t state_reg, state_next;

    logic signed [SUM_W-1:0] ab_reg;
    logic                    ovf_reg;
    logic [NORM_W-1:0]       na_reg, nb_reg;
    logic                    zero_reg;
    logic [DEN_W-1:0]        den_reg;
    logic [DVD_W-1:0]        dvd_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [QT_W-1:0]         q_reg;
    logic                    big_reg;
    logic [DIV_CNT_W-1:0]    cnt_reg;

    logic                    sq_done_a, sq_done_b;
    logic [ROOT_W-1:0]       root_a, root_b;
    logic [SUM_W-1:0]        rad_a, rad_b;
    logic [NORM_W-1:0]       na_sat, nb_sat;
    logic [SUM_W-1:0]        mag;
    logic [DEN_W:0]          rem_sh;
    logic                    ge;
    logic                    div_last;
    logic signed [SIM_W-1:0] sim;

    // negative sums have a zero norm
    assign rad_a = rd_data.sum_aa[SUM_W-1] ? '0 : rd_data.sum_aa;
    assign rad_b = rd_data.sum_bb[SUM_W-1] ? '0 : rd_data.sum_bb;

    cse_isqrt u_sqrt_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pop),
        .value   (rad_a),
        .done    (sq_done_a),
        .root    (root_a)
    );

    cse_isqrt u_sqrt_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (pop),
        .value   (rad_b),
        .done    (sq_done_b),
        .root    (root_b)
    );

    assign na_sat = (root_a[ROOT_W-1:NORM_W] != '0) ? NORM_MAX : root_a[NORM_W-1:0];
    assign nb_sat = (root_b[ROOT_W-1:NORM_W] != '0) ? NORM_MAX : root_b[NORM_W-1:0];

    assign div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!fifo_empty) state_next = BK_SQRT;
            BK_SQRT: if (sq_done_a) state_next = BK_MUL;
            BK_MUL:  state_next = zero_reg ? BK_OUT : BK_PREP;
            BK_PREP: state_next = BK_DIV;
            BK_DIV:  if (div_last) state_next = BK_OUT;
            BK_OUT:  if (m_ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop     = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            BK_IDLE: pop = !fifo_empty;
            BK_OUT:  m_valid = 1'b1;
            default: begin
                pop     = 1'b0;
                m_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // restoring divide step
    assign mag    = ab_reg[SUM_W-1] ? (SUM_W'(0) - SUM_W'(ab_reg)) : SUM_W'(ab_reg);
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign ge     = (rem_sh >= {1'b0, den_reg});

    // datapath
    always_ff @(posedge aclk) begin
        if (pop) begin
            ab_reg  <= rd_data.sum_ab;
            ovf_reg <= rd_data.ovf;
        end
        if (state_reg == BK_SQRT && sq_done_a) begin
            na_reg   <= na_sat;
            nb_reg   <= nb_sat;
            zero_reg <= (na_sat == '0) || (nb_sat == '0);
        end
        if (state_reg == BK_MUL) begin
            den_reg <= na_reg * nb_reg;
        end
        if (state_reg == BK_PREP) begin
            dvd_reg <= {mag, FRAC_SHIFT'(0)} + DVD_W'(den_reg >> 1);
            rem_reg <= '0;
            q_reg   <= '0;
            big_reg <= 1'b0;
            cnt_reg <= '0;
        end
        if (state_reg == BK_DIV) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= ge ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
            q_reg   <= {q_reg[QT_W-2:0], ge};
            big_reg <= big_reg || q_reg[QT_W-1];
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // rounded quotient to saturated Q1.15
    always_comb begin
        if (zero_reg) begin
            sim = '0;
        end else if (ab_reg[SUM_W-1]) begin
            if (big_reg || (q_reg > QT_W'(32768))) begin
                sim = SIM_MIN;
            end else begin
                sim = SIM_W'(QT_W'(0) - q_reg);
            end
        end else begin
            if (big_reg || (q_reg > QT_W'(32767))) begin
                sim = SIM_MAX;
            end else begin
                sim = SIM_W'(q_reg);
            end
        end
    end

    assign m_similarity  = sim;
    assign m_dot_product = ab_reg;
    assign m_norm_a      = na_reg;
    assign m_norm_b      = nb_reg;
    assign m_zero_norm   = zero_reg;
    assign m_overflow    = ovf_reg;

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_SQRT && sq_done_a) |-> sq_done_b)
        else $error("root units out of step");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DIV) |-> (den_reg != '0))
        else $error("divide started with a zero denominator");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_norm) |-> (m_norm_a == '0 || m_norm_b == '0))
        else $error("zero flag without a zero norm");
`endif

endmodule

/* hdl/cosine_similarity_engine_unit.sv */
// Cosine similarity of two vectors streamed as signed Q4.12 element pairs. One pair
// is taken per cycle while no last pair waits on a full queue; a two-stage front
// multiplies and accumulates saturating 48-bit sums of a*b, a*a and b*b (elements
// past MAX_LEN are dropped and flag overflow). The pair marked last closes the
// vector and its sums go to a two-entry queue. The back end turns each queued
// entry into one result: it pops the entry, runs the two bit-serial square roots,
// forms the norm product and sets up the dividend, runs the restoring 63-bit divide
// and presents the result until it is taken; only then does it pop the next entry,
// while short bursts of vectors are absorbed by the queue. When either norm is zero
// the divide is skipped.
module cosine_similarity_engine_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [cse_pkg::ELEM_W-1:0] s_elem_a,
    input  logic signed [cse_pkg::ELEM_W-1:0] s_elem_b,
    input  logic                              s_last_elem,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [cse_pkg::SIM_W-1:0]  m_similarity,
    output logic signed [cse_pkg::SUM_W-1:0]  m_dot_product,
    output logic [cse_pkg::NORM_W-1:0]        m_norm_a,
    output logic [cse_pkg::NORM_W-1:0]        m_norm_b,
    output logic                              m_zero_norm,
    output logic                              m_overflow
);
    import cse_pkg::*;

    logic      push, fifo_full, fifo_empty, pop;
    acc_snap_t push_data, rd_data;

    // accumulate front
    cse_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_elem_a    (s_elem_a),
        .s_elem_b    (s_elem_b),
        .s_last_elem (s_last_elem),
        .push        (push),
        .push_data   (push_data),
        .fifo_full   (fifo_full)
    );

    // queue of finished sums
    cse_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data (push_data),
        .full    (fifo_full),
        .rd_en   (pop),
        .rd_data (rd_data),
        .empty   (fifo_empty)
    );

    // root, divide and result register
    cse_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fifo_empty    (fifo_empty),
        .pop           (pop),
        .rd_data       (rd_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_similarity  (m_similarity),
        .m_dot_product (m_dot_product),
        .m_norm_a      (m_norm_a),
        .m_norm_b      (m_norm_b),
        .m_zero_norm   (m_zero_norm),
        .m_overflow    (m_overflow)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int HOLD_CYCLES  = 600;
    localparam int RAND_ITEMS   = 660;
    localparam int DRAIN_GUARD  = 20000;
    localparam int SETTLE_TIME  = 300;
    localparam longint SUM_HI   = (longint'(1) <<< 47) - 1;
    localparam longint SUM_LO   = -SUM_HI - 1;

    // one cosine result as it leaves the block
    typedef struct packed {
        logic signed [cse_pkg::SIM_W-1:0] sim;
        logic signed [cse_pkg::SUM_W-1:0] dot;
        logic [cse_pkg::NORM_W-1:0]       na;
        logic [cse_pkg::NORM_W-1:0]       nb;
        logic                             zero;
        logic                             ovf;
    } cos_result_t;

    // one row of the hand-built stimulus
    typedef struct {
        logic signed [cse_pkg::ELEM_W-1:0] a;
        logic signed [cse_pkg::ELEM_W-1:0] b;
        logic                              fin;
        bit                                pinned;
        cos_result_t                       res;
    } stim_row_t;

    typedef enum int {
        VEC_MIXED,
        VEC_SAME,
        VEC_NEGATED,
        VEC_HALVED,
        VEC_A_ZERO,
        VEC_B_ZERO
    } vec_kind_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic signed [cse_pkg::ELEM_W-1:0] s_elem_a;
    logic signed [cse_pkg::ELEM_W-1:0] s_elem_b;
    logic                              s_last_elem;
    logic                              m_valid;
    logic                              m_ready;
    logic signed [cse_pkg::SIM_W-1:0]  m_similarity;
    logic signed [cse_pkg::SUM_W-1:0]  m_dot_product;
    logic [cse_pkg::NORM_W-1:0]        m_norm_a;
    logic [cse_pkg::NORM_W-1:0]        m_norm_b;
    logic                              m_zero_norm;
    logic                              m_overflow;

    // predictor state: running sums of the vector pair in flight
    longint      run_ab = 0;
    longint      run_aa = 0;
    longint      run_bb = 0;
    int          run_count = 0;
    bit          run_ovf = 1'b0;

    cos_result_t queued_cosines[$];
    int          fail_count = 0;
    int          items_sent = 0;
    int          vectors_sent = 0;
    bit          gaps_on = 1'b1;
    bit          jitter_on = 1'b1;
    bit          hold_req = 1'b0;

    // hand-worked rows carry their result; the rest go through the predictor
    stim_row_t stim_rows [23] = '{
        '{0, 0, 1, 1, '{0, 0, 0, 0, 1, 0}},
        '{-32768, -32768, 1, 1, '{cse_pkg::SIM_MAX, 1073741824, 32768, 32768, 0, 0}},
        '{32767, -32768, 1, 1, '{cse_pkg::SIM_MIN, -1073709056, 32767, 32768, 0, 0}},
        '{32767, 32767, 1, 1, '{cse_pkg::SIM_MAX, 1073676289, 32767, 32767, 0, 0}},
        '{4096, 0, 1, 1, '{0, 0, 4096, 0, 1, 0}},
        '{0, -1, 1, 1, '{0, 0, 0, 1, 1, 0}},
        '{-1, -1, 1, 1, '{cse_pkg::SIM_MAX, 1, 1, 1, 0, 0}},
        '{1, -1, 1, 1, '{cse_pkg::SIM_MIN, -1, 1, 1, 0, 0}},
        '{4096, 0, 0, 0, '0},
        '{0, 4096, 1, 1, '{0, 0, 4096, 4096, 0, 0}},
        '{4096, 4096, 0, 0, '0},
        '{0, 4096, 1, 0, '0},
        '{0, 0, 0, 0, '0},
        '{0, 0, 1, 1, '{0, 0, 0, 0, 1, 0}},
        '{1, 1, 0, 0, '0},
        '{-1, 1, 0, 0, '0},
        '{2, -3, 1, 0, '0},
        '{21845, -21846, 1, 0, '0},
        '{-21846, 21845, 1, 0, '0},
        '{-32768, 32767, 0, 0, '0},
        '{32767, -32768, 1, 0, '0},
        '{-4096, 2048, 0, 0, '0},
        '{-4096, 6144, 1, 0, '0}
    };

    cosine_similarity_engine_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_elem_a      (s_elem_a),
        .s_elem_b      (s_elem_b),
        .s_last_elem   (s_last_elem),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_similarity  (m_similarity),
        .m_dot_product (m_dot_product),
        .m_norm_a      (m_norm_a),
        .m_norm_b      (m_norm_b),
        .m_zero_norm   (m_zero_norm),
        .m_overflow    (m_overflow)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop if the run hangs
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic log_failure(input string what);
        if (fail_count < 10) begin
            $display("%0t: %s", $time, what);
        end
        fail_count++;
    endtask

    function automatic longint clamp_sum(input longint x);
        if (x > SUM_HI) begin
            return SUM_HI;
        end
        if (x < SUM_LO) begin
            return SUM_LO;
        end
        return x;
    endfunction

    // floor of the square root, one result bit per pass from the top
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int k = 31; k >= 0; k--) begin
            trial = root | (64'd1 << k);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic logic [cse_pkg::NORM_W-1:0] norm_of_sum(input longint s);
        longint unsigned r;
        if (s <= 0) begin
            return '0;
        end
        r = floor_root(longint'(s));
        if (r > cse_pkg::NORM_MAX) begin
            return cse_pkg::NORM_MAX;
        end
        return r[cse_pkg::NORM_W-1:0];
    endfunction

    // fold one element pair into the sums; the closing pair queues a result
    task automatic fold_pair(input logic signed [cse_pkg::ELEM_W-1:0] a,
                             input logic signed [cse_pkg::ELEM_W-1:0] b,
                             input logic fin);
        cos_result_t     r;
        longint unsigned mag;
        longint unsigned den;
        longint unsigned q;
        bit              neg;
        if (run_count < cse_pkg::MAX_LEN) begin
            run_ab = clamp_sum(run_ab + longint'(a) * longint'(b));
            run_aa = clamp_sum(run_aa + longint'(a) * longint'(a));
            run_bb = clamp_sum(run_bb + longint'(b) * longint'(b));
            run_count++;
        end else begin
            run_ovf = 1'b1;
        end
        if (!fin) begin
            return;
        end

        r.na   = norm_of_sum(run_aa);
        r.nb   = norm_of_sum(run_bb);
        r.zero = (r.na == 0) || (r.nb == 0);
        r.dot  = run_ab[cse_pkg::SUM_W-1:0];
        r.ovf  = run_ovf;
        r.sim  = '0;

        // rounded ratio in Q1.15, clipped at both ends
        if (!r.zero) begin
            neg = run_ab < 0;
            mag = neg ? 64'(-run_ab) : 64'(run_ab);
            den = r.na * r.nb;
            q   = ((mag << 15) + (den >> 1)) / den;
            if (neg) begin
                r.sim = (q > 32768) ? cse_pkg::SIM_MIN : 16'(64'd0 - q);
            end else begin
                r.sim = (q > 32767) ? cse_pkg::SIM_MAX : 16'(q);
            end
        end
        queued_cosines.push_back(r);

        run_ab    = 0;
        run_aa    = 0;
        run_bb    = 0;
        run_count = 0;
        run_ovf   = 1'b0;
    endtask

    // offer one element pair, wait for it to be taken, then maybe idle
    task automatic push_pair(input logic signed [cse_pkg::ELEM_W-1:0] a,
                             input logic signed [cse_pkg::ELEM_W-1:0] b,
                             input logic fin);
        int n;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_elem_a    <= a;
        s_elem_b    <= b;
        s_last_elem <= fin;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        fold_pair(a, b, fin);
        items_sent++;
        if (fin) begin
            vectors_sent++;
        end
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 4);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    function automatic logic signed [cse_pkg::ELEM_W-1:0] draw_elem();
        case ($urandom_range(0, 5))
            0, 1: return 16'($urandom);
            2: return 16'($urandom_range(0, 128)) - 16'sd64;
            3: return 16'($urandom_range(0, 8192)) - 16'sd4096;
            4: begin
                case ($urandom_range(0, 3))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            default: return '0;
        endcase
    endfunction

    // mostly short vectors, now and then a longer one
    function automatic int draw_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
    endfunction

    // one vector pair of the given length with a random relation between a and b
    task automatic send_vector(input int len);
        vec_kind_t                         kind;
        logic signed [cse_pkg::ELEM_W-1:0] ea;
        logic signed [cse_pkg::ELEM_W-1:0] eb;
        case ($urandom_range(0, 9))
            5: kind = VEC_SAME;
            6: kind = VEC_NEGATED;
            7: kind = VEC_HALVED;
            8: kind = VEC_A_ZERO;
            9: kind = VEC_B_ZERO;
            default: kind = VEC_MIXED;
        endcase
        for (int i = 0; i < len; i++) begin
            ea = draw_elem();
            eb = draw_elem();
            case (kind)
                VEC_SAME:    eb = ea;
                VEC_NEGATED: eb = -ea;
                VEC_HALVED:  eb = ea >>> 1;
                VEC_A_ZERO:  ea = '0;
                VEC_B_ZERO:  eb = '0;
                default:     ;
            endcase
            push_pair(ea, eb, i == len - 1);
        end
    endtask

    // result sink: short random stalls, one long hold-off on request
    initial begin : result_sink
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (jitter_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 4);
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // compare each delivered result against the oldest open request
    always @(posedge aclk) begin : cosine_check
        cos_result_t got;
        cos_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_similarity, m_dot_product, m_norm_a, m_norm_b,
                    m_zero_norm, m_overflow};
            if (queued_cosines.size() == 0) begin
                log_failure($sformatf("result with no open request: sim=%0d dot=%0d",
                                      got.sim, got.dot));
            end else begin
                want = queued_cosines.pop_front();
                if (got.sim !== want.sim || got.dot !== want.dot || got.na !== want.na
                        || got.nb !== want.nb || got.zero !== want.zero
                        || got.ovf !== want.ovf) begin
                    log_failure($sformatf(
                        {"cosine result differs: want sim=%0d dot=%0d na=%0d nb=%0d ",
                         "zero=%0b ovf=%0b, got sim=%0d dot=%0d na=%0d nb=%0d ",
                         "zero=%0b ovf=%0b"},
                        want.sim, want.dot, want.na, want.nb, want.zero, want.ovf,
                        got.sim, got.dot, got.na, got.nb, got.zero, got.ovf));
                end
            end
        end
    end

    initial begin : stimulus
        int base;
        int guard;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_elem_a    = '0;
        s_elem_b    = '0;
        s_last_elem = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // hand-built corner vectors
        foreach (stim_rows[i]) begin
            push_pair(stim_rows[i].a, stim_rows[i].b, stim_rows[i].fin);
            // pin the hand-worked result in place of the predicted one
            if (stim_rows[i].pinned) begin
                queued_cosines[queued_cosines.size() - 1] = stim_rows[i].res;
            end
        end

        // full-length vector at the largest products, then one past the limit
        for (int i = 0; i < cse_pkg::MAX_LEN; i++) begin
            push_pair(-16'sd32768, -16'sd32768, i == cse_pkg::MAX_LEN - 1);
        end
        for (int i = 0; i < cse_pkg::MAX_LEN + 4; i++) begin
            push_pair(draw_elem(), draw_elem(), i == cse_pkg::MAX_LEN + 3);
        end

        // random vectors
        base = items_sent;
        while (items_sent - base < RAND_ITEMS * 2 / 5) begin
            send_vector(draw_len());
        end

        // long sink hold-off while short vectors keep coming
        hold_req = 1'b1;
        repeat (25) send_vector($urandom_range(1, 3));

        while (items_sent - base < RAND_ITEMS * 5 / 6 || vectors_sent < 160) begin
            send_vector(draw_len());
        end

        // closing stretch with both sides flat out
        gaps_on   = 1'b0;
        jitter_on = 1'b0;
        while (items_sent - base < RAND_ITEMS) begin
            send_vector(draw_len());
        end

        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then give the back end time to show any stray result
        guard = 0;
        while (queued_cosines.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_TIME) @(posedge aclk);
        if (queued_cosines.size() != 0) begin
            log_failure($sformatf("%0d requests never answered", queued_cosines.size()));
        end

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/cse_pkg.sv
hdl/cse_front.sv
hdl/cse_fifo.sv
hdl/cse_isqrt.sv
hdl/cse_back.sv
hdl/cosine_similarity_engine_unit.sv
dv/tb_top.sv
